/* src/fpw_pkg.sv */
package fpw_pkg;

  localparam int MaxRowsDef  = 4096;
  localparam int MaxColsDef  = 4096;
  localparam int FracBitsDef = 16;

  localparam int QBits = 18;
  localparam int VW    = 64;
  localparam int WW    = 94;
  localparam int RW    = 112;
  localparam int QW    = 112;
  localparam int DW    = 132;

  typedef struct packed {
    logic signed [31:0] src_det_x;
    logic signed [31:0] src_det_y;
    logic signed [31:0] src_det_z;
    logic signed [31:0] col_step_x;
    logic signed [31:0] col_step_y;
    logic signed [31:0] col_step_z;
    logic signed [31:0] row_step_x;
    logic signed [31:0] row_step_y;
    logic signed [31:0] row_step_z;
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [QBits-1:0] weight;
    logic             zero_fault;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             fault;
    logic [QBits-1:0] q;
    logic [WW-1:0]    w;
    logic [RW-1:0]    rem;
    logic [QW-1:0]    qw;
  } cell_t;

  typedef struct packed {
    logic          valid;
    logic [VW-1:0] vsq;
    logic [WW-1:0] wsq;
  } sums_t;

endpackage

/* src/fdk_pixel_weight_unit.sv */
// Pipeline from start to done: 5 front stages, then 18 cells.
// Throughput: one item per cycle; busy is always low.
// Each cell of the chain settles one weight bit, most significant first.
// Reset (rst, synchronous) clears the valid pipeline and the cell chain.
// The receiver cannot stall: done is high for one cycle per item.
module fdk_pixel_weight_unit
  import fpw_pkg::*;
#(
  parameter int MAX_ROWS  = MaxRowsDef,
  parameter int MAX_COLS  = MaxColsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  pixel_t  pixel,
  output logic    done,
  output result_t result
);

  sums_t sums;
  cell_t chain [QBits+1];

  assign busy = 1'b0;

  fpw_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .load (start),
    .pixel(pixel),
    .sums (sums)
  );

  always_comb begin
    chain[0].valid = sums.valid;
    chain[0].fault = (sums.wsq == '0);
    chain[0].q     = '0;
    chain[0].w     = sums.wsq;
    chain[0].rem   = RW'(sums.vsq) << (2 * FRAC_BITS);
    chain[0].qw    = '0;
  end

  for (genvar i = 0; i < QBits; i++) begin : g_cell
    fpw_cell #(
      .BIT(QBits - 1 - i)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .prev(chain[i]),
      .cur (chain[i+1])
    );
  end

  assign done              = chain[QBits].valid;
  assign result.weight     = chain[QBits].fault ? '0 : chain[QBits].q;
  assign result.zero_fault = chain[QBits].fault;

endmodule

/* src/fpw_front.sv */
module fpw_front
  import fpw_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  pixel_t pixel,
  output sums_t  sums
);

  localparam logic [31:0] RowLim = 32'(MAX_ROWS - 1);
  localparam logic [31:0] ColLim = 32'(MAX_COLS - 1);

  logic [3:0] valid;
  logic signed [31:0] vin [3];
  logic signed [31:0] rin [3];
  logic signed [31:0] cin [3];
  logic [31:0]        vmag [3];
  logic [11:0] row_c;
  logic [11:0] col_c;

  logic signed [31:0] v1  [3];
  logic signed [44:0] pr1 [3];
  logic signed [44:0] pc1 [3];
  logic [63:0]        vs1 [3];
  logic signed [46:0] w2  [3];
  logic [VW-1:0]      vsq2, vsq3, vsq4, vsq5;
  logic [45:0]        m3  [3];
  logic [45:0]        hh4 [3];
  logic [46:0]        hl4 [3];
  logic [45:0]        ll4 [3];
  logic [WW-1:0]      wsq_next;
  logic [WW-1:0]      wsq5;
  logic               sums_valid;

  assign vin = '{pixel.src_det_x, pixel.src_det_y, pixel.src_det_z};
  assign cin = '{pixel.col_step_x, pixel.col_step_y, pixel.col_step_z};
  assign rin = '{pixel.row_step_x, pixel.row_step_y, pixel.row_step_z};

  always_comb begin
    row_c = (32'(pixel.pixel_row) > RowLim) ? RowLim[11:0] : pixel.pixel_row;
    col_c = (32'(pixel.pixel_col) > ColLim) ? ColLim[11:0] : pixel.pixel_col;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vmag[k] = vin[k][31] ? 32'(-vin[k]) : 32'(vin[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], load};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      v1[k]  <= vin[k];
      pr1[k] <= 45'($signed({1'b0, row_c})) * 45'(rin[k]);
      pc1[k] <= 45'($signed({1'b0, col_c})) * 45'(cin[k]);
      vs1[k] <= 64'(vmag[k]) * 64'(vmag[k]);
      w2[k]  <= 47'(v1[k]) + 47'(pr1[k]) + 47'(pc1[k]);
      m3[k]  <= w2[k][46] ? 46'(-w2[k]) : 46'(w2[k]);
      hh4[k] <= 46'(m3[k][45:23]) * 46'(m3[k][45:23]);
      hl4[k] <= 47'(m3[k][45:23]) * 47'(m3[k][22:0]);
      ll4[k] <= 46'(m3[k][22:0]) * 46'(m3[k][22:0]);
    end
    vsq2 <= VW'(vs1[0]) + VW'(vs1[1]) + VW'(vs1[2]);
    vsq3 <= vsq2;
    vsq4 <= vsq3;
    wsq5 <= wsq_next;
    vsq5 <= vsq4;
  end

  always_comb begin
    wsq_next = '0;
    for (int k = 0; k < 3; k++) begin
      wsq_next = wsq_next + (WW'(hh4[k]) << 46) + (WW'(hl4[k]) << 24) + WW'(ll4[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
    end else begin
      sums_valid <= valid[3];
    end
  end

  assign sums = '{valid: sums_valid, vsq: vsq5, wsq: wsq5};

endmodule

/* src/fpw_cell.sv */
module fpw_cell
  import fpw_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cell_t prev,
  output cell_t cur
);

  logic [DW-1:0] delta;
  logic          take;
  cell_t         cur_next;

  always_comb begin
    delta = (DW'(prev.qw) << (BIT + 1)) + (DW'(prev.w) << (2 * BIT));
    take  = delta <= DW'(prev.rem);
    cur_next = prev;
    if (take) begin
      cur_next.rem    = prev.rem - delta[RW-1:0];
      cur_next.qw     = prev.qw + (QW'(prev.w) << BIT);
      cur_next.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule
